/* rtl/core/mouse_quadrature_tick_pacer_unit_assert.svh */
// Assertion macros used by the pacer RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef MOUSE_QUADRATURE_TICK_PACER_UNIT_ASSERT_SVH
`define MOUSE_QUADRATURE_TICK_PACER_UNIT_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define MQTP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// When the antecedent holds, the consequent must hold in the next cycle.
`define MQTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/mqtp_pkg.sv */
// Types and constants of the quadrature tick pacer.
// Depends on nothing; used by every module of the block.
package mqtp_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [14:0] MAX_BACKLOG_RST       = 15'd4096;
    localparam logic [15:0] TRANSITION_PERIOD_RST = 16'd0;

    typedef enum logic [1:0] {
        CMD_MOVE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_BACKLOG       = 1'd0,
        REG_TRANSITION_PERIOD = 1'd1
    } t_cfg_reg;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [11:0] delta_x;
        logic signed [11:0] delta_y;
    } t_in_beat;

    typedef struct packed {
        logic               x_fired;
        logic               x_positive;
        logic               y_fired;
        logic               y_positive;
        logic               irq_level;
        logic signed [15:0] backlog_x;
        logic signed [15:0] backlog_y;
    } t_out_beat;

    typedef struct packed {
        logic [14:0] max_backlog;
        logic [15:0] transition_period;
    } t_cfg;

endpackage

/* rtl/core/mqtp_cfg_regs.sv */
// Configuration register file of the quadrature tick pacer.
// Depends on mqtp_pkg for the register codes and the configuration struct.
module mqtp_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mqtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mqtp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mqtp_pkg::t_cfg                  o_cfg
);

    mqtp_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_backlog       <= mqtp_pkg::MAX_BACKLOG_RST;
            r_cfg.transition_period <= mqtp_pkg::TRANSITION_PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (mqtp_pkg::t_cfg_reg'(i_cfg_index))
                mqtp_pkg::REG_MAX_BACKLOG: begin
                    r_cfg.max_backlog <= i_cfg_data[14:0];
                end
                mqtp_pkg::REG_TRANSITION_PERIOD: begin
                    r_cfg.transition_period <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/core/mqtp_core.sv */
// Backlog, step and pacing state of the quadrature tick pacer with its update logic.
// Depends on mqtp_pkg and on the assertion macro header.
`include "mouse_quadrature_tick_pacer_unit_assert.svh"

module mqtp_core #(
    parameter int BACKLOG_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  mqtp_pkg::t_in_beat  i_beat,
    input  mqtp_pkg::t_cfg      i_cfg,
    output mqtp_pkg::t_out_beat o_beat
);

    localparam int SW = ((BACKLOG_BITS > 16) ? BACKLOG_BITS : 16) + 2;
    localparam logic [SW-1:0] CAP = SW'((64'd1 << (BACKLOG_BITS - 1)) - 64'd1);

    logic signed [BACKLOG_BITS-1:0] r_pend_x, n_pend_x;
    logic signed [BACKLOG_BITS-1:0] r_pend_y, n_pend_y;
    logic [1:0]                     r_step_x, n_step_x;
    logic [1:0]                     r_step_y, n_step_y;
    logic                           r_irq, n_irq;
    logic [15:0]                    r_since, n_since;
    logic                           r_started, n_started;

    logic [SW-1:0]        max_ext;
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] px_ext, py_ext, dx_ext, dy_ext;
    logic signed [SW-1:0] sx_ext, sy_ext;
    logic signed [SW-1:0] nx_ext, ny_ext;
    logic [15:0]          since_inc;

    function automatic logic signed [SW-1:0] clamp_lim(
        input logic signed [SW-1:0] v,
        input logic signed [SW-1:0] l
    );
        logic signed [SW-1:0] r;
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] step_val(input logic [1:0] s);
        logic signed [SW-1:0] r;
        if (!s[1]) begin
            r = '0;
        end else if (s[0]) begin
            r = SW'(1);
        end else begin
            r = '1;
        end
        return r;
    endfunction

    assign max_ext = {{(SW - 15){1'b0}}, i_cfg.max_backlog};
    assign lim     = (max_ext < CAP) ? max_ext : CAP;

    assign px_ext = {{(SW - BACKLOG_BITS){r_pend_x[BACKLOG_BITS-1]}}, r_pend_x};
    assign py_ext = {{(SW - BACKLOG_BITS){r_pend_y[BACKLOG_BITS-1]}}, r_pend_y};
    assign dx_ext = {{(SW - 12){i_beat.delta_x[11]}}, i_beat.delta_x};
    assign dy_ext = -{{(SW - 12){i_beat.delta_y[11]}}, i_beat.delta_y};
    assign sx_ext = step_val(r_step_x);
    assign sy_ext = step_val(r_step_y);

    assign since_inc = (r_since != 16'hFFFF) ? r_since + 16'd1 : r_since;

    always_comb begin
        n_pend_x  = r_pend_x;
        n_pend_y  = r_pend_y;
        n_step_x  = r_step_x;
        n_step_y  = r_step_y;
        n_irq     = r_irq;
        n_since   = r_since;
        n_started = r_started;
        o_beat    = '0;
        unique case (i_beat.cmd)
            mqtp_pkg::CMD_MOVE: begin
                if (i_beat.delta_x != '0) begin
                    n_pend_x = BACKLOG_BITS'(clamp_lim(px_ext + dx_ext, lim));
                end
                if (i_beat.delta_y != '0) begin
                    n_pend_y = BACKLOG_BITS'(clamp_lim(py_ext + dy_ext, lim));
                end
            end
            mqtp_pkg::CMD_TICK: begin
                n_since = since_inc;
                if (!r_irq && (r_pend_x != '0 || r_pend_y != '0)) begin
                    if (i_cfg.transition_period == '0) begin
                        n_irq = 1'b1;
                    end else if (!r_started || since_inc >= i_cfg.transition_period) begin
                        n_irq     = 1'b1;
                        n_started = 1'b1;
                        n_since   = '0;
                    end
                end
                if (n_irq && !r_irq) begin
                    n_step_x = {r_pend_x != '0, !r_pend_x[BACKLOG_BITS-1] && r_pend_x != '0};
                    n_step_y = {r_pend_y != '0, !r_pend_y[BACKLOG_BITS-1] && r_pend_y != '0};
                end
            end
            mqtp_pkg::CMD_READ: begin
                o_beat.x_fired    = r_step_x[1];
                o_beat.x_positive = r_step_x[0];
                o_beat.y_fired    = r_step_y[1];
                o_beat.y_positive = r_step_y[0];
                if (r_irq) begin
                    n_pend_x = BACKLOG_BITS'(clamp_lim(px_ext - sx_ext, lim));
                    n_pend_y = BACKLOG_BITS'(clamp_lim(py_ext - sy_ext, lim));
                    n_step_x = '0;
                    n_step_y = '0;
                    n_irq    = 1'b0;
                end
            end
            default: begin
            end
        endcase
        nx_ext = {{(SW - BACKLOG_BITS){n_pend_x[BACKLOG_BITS-1]}}, n_pend_x};
        ny_ext = {{(SW - BACKLOG_BITS){n_pend_y[BACKLOG_BITS-1]}}, n_pend_y};
        o_beat.irq_level = n_irq;
        o_beat.backlog_x = nx_ext[15:0];
        o_beat.backlog_y = ny_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_x  <= '0;
            r_pend_y  <= '0;
            r_step_x  <= '0;
            r_step_y  <= '0;
            r_irq     <= 1'b0;
            r_since   <= '0;
            r_started <= 1'b0;
        end else if (i_accept) begin
            r_pend_x  <= n_pend_x;
            r_pend_y  <= n_pend_y;
            r_step_x  <= n_step_x;
            r_step_y  <= n_step_y;
            r_irq     <= n_irq;
            r_since   <= n_since;
            r_started <= n_started;
        end
    end

    `MQTP_ASSERT_ALWAYS(a_irq_has_step, i_clk, i_rst_n, !r_irq || r_step_x[1] || r_step_y[1])
    `MQTP_ASSERT_ALWAYS(a_idle_no_step, i_clk, i_rst_n, r_irq || (r_step_x == '0 && r_step_y == '0))
    `MQTP_ASSERT_NEXT(a_read_drops_irq, i_clk, i_rst_n, i_accept && i_beat.cmd == mqtp_pkg::CMD_READ, !r_irq)
    `MQTP_ASSERT_NEXT(a_steps_held, i_clk, i_rst_n, i_accept && r_irq && i_beat.cmd != mqtp_pkg::CMD_READ, $stable(r_step_x) && $stable(r_step_y))

endmodule

/* rtl/core/mouse_quadrature_tick_pacer_unit.sv */
// Quadrature tick pacer: saturating X/Y backlogs paced into quadrature steps.
// Output: the result beat of each accepted input beat is registered in the output register.
// Throughput: one beat per cycle unless stalled; the output frees on the same edge it is taken.
// Reset: synchronous, active low; clears backlogs, steps, interrupt, pacing state and output valid.
// Depends on mqtp_pkg, mqtp_cfg_regs and mqtp_core.
module mouse_quadrature_tick_pacer_unit #(
    parameter int BACKLOG_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mqtp_pkg::t_in_beat              i_in_beat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mqtp_pkg::t_out_beat             o_out_beat,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mqtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mqtp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mqtp_pkg::t_cfg      cfg;
    mqtp_pkg::t_out_beat core_beat;
    mqtp_pkg::t_out_beat r_out_beat;
    logic                r_out_valid;
    logic                in_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    mqtp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mqtp_core #(
        .BACKLOG_BITS (BACKLOG_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_beat   (i_in_beat),
        .i_cfg    (cfg),
        .o_beat   (core_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_beat <= core_beat;
        end
    end

endmodule
